FILE: rtl/quadratic_bisection_root_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quadratic bisection root finder
// Implication checks clocked on a rising edge and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef QUADRATIC_BISECTION_ROOT_ASSERT_SVH
`define QUADRATIC_BISECTION_ROOT_ASSERT_SVH

// Same-cycle implication.
`define QBR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error("%m: check failed");

// Next-cycle implication.
`define QBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error("%m: check failed");

`endif

FILE: rtl/qbr_pkg.sv
// ---------------------------------------------------------------------------
// qbr_pkg
// Widths, register indexes, control word layout and step addresses shared
// by the bisection root finder modules.
// ---------------------------------------------------------------------------
package qbr_pkg;

    localparam int VALUE_W = 32;
    localparam int FRAC_W  = 16;

    // Horner intermediate t = c2*x + c1*2^F, split into low and high words
    localparam int T_W   = ((2 * VALUE_W > VALUE_W + FRAC_W) ?
                            2 * VALUE_W : VALUE_W + FRAC_W) + 1;
    localparam int MA_W  = T_W - VALUE_W;
    localparam int P_W   = MA_W + VALUE_W;
    // Full polynomial value t*x + c0*2^(2F)
    localparam int ACC_W = ((T_W + VALUE_W > VALUE_W + 2 * FRAC_W) ?
                            T_W + VALUE_W : VALUE_W + 2 * FRAC_W) + 1;

    localparam int TOL_W    = VALUE_W - 1;
    localparam int IN_TW    = ((2 * VALUE_W + 7) / 8) * 8;
    localparam int OUT_TW   = ((VALUE_W + 2 + 7) / 8) * 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SQUARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 2'd3;

    localparam logic signed [VALUE_W-1:0] C2_RESET = VALUE_W'(64'sd1 <<< FRAC_W);
    localparam logic signed [VALUE_W-1:0] C1_RESET = VALUE_W'(-64'sd5 <<< FRAC_W);
    localparam logic signed [VALUE_W-1:0] C0_RESET = VALUE_W'(64'sd3 <<< FRAC_W);
    localparam logic [TOL_W-1:0]          TOL_MIN  = TOL_W'(2);

    localparam logic [1:0] ST_WIDTH  = 2'd0;
    localparam logic [1:0] ST_EXACT  = 2'd1;
    localparam logic [1:0] ST_NOSIGN = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] c2;
        logic signed [VALUE_W-1:0] c1;
        logic signed [VALUE_W-1:0] c0;
        logic [TOL_W-1:0]          tol;
    } t_cfg;

    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_NO_INPUT, C_ZERO, C_SAME, C_NARROW, C_WIDE
    } t_cond;

    typedef enum logic [1:0] {MUL_NONE, MUL_C2X, MUL_LOX, MUL_HIX} t_mul;
    typedef enum logic [1:0] {ADD_NONE, ADD_T_FORM, ADD_A_INIT, ADD_A_HI} t_add;
    typedef enum logic [1:0] {X_HOLD, X_IN, X_B, X_MID} t_xsel;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_LOAD, ACT_SAVE_SA, ACT_UPDATE,
        ACT_EMIT_A, ACT_EMIT_B, ACT_EMIT_NONE, ACT_EMIT_MID, ACT_EMIT_X
    } t_act;

    localparam int PC_W = 5;

    typedef struct packed {
        t_cond           cond;
        logic [PC_W-1:0] target;
        t_mul            mul;
        t_add            add;
        t_xsel           xsel;
        t_act            act;
        logic [1:0]      status;
    } t_ctrl;

    typedef struct packed {
        logic zero;
        logic same;
        logic narrow;
    } t_flags;

    // Program addresses; each evaluation block is five steps long
    localparam logic [PC_W-1:0] PC_IDLE     = 5'd0;
    localparam logic [PC_W-1:0] PC_EVA      = 5'd1;
    localparam logic [PC_W-1:0] PC_A_CHK    = 5'd6;
    localparam logic [PC_W-1:0] PC_EVB      = 5'd7;
    localparam logic [PC_W-1:0] PC_B_CHK    = 5'd12;
    localparam logic [PC_W-1:0] PC_SIGN     = 5'd13;
    localparam logic [PC_W-1:0] PC_LOOP     = 5'd14;
    localparam logic [PC_W-1:0] PC_EVM      = 5'd15;
    localparam logic [PC_W-1:0] PC_M_CHK    = 5'd20;
    localparam logic [PC_W-1:0] PC_TAIL     = 5'd21;
    localparam logic [PC_W-1:0] PC_FIN_MID  = 5'd22;
    localparam logic [PC_W-1:0] PC_FIN_A    = 5'd23;
    localparam logic [PC_W-1:0] PC_FIN_B    = 5'd24;
    localparam logic [PC_W-1:0] PC_FIN_NONE = 5'd25;
    localparam logic [PC_W-1:0] PC_FIN_X    = 5'd26;

endpackage

FILE: rtl/qbr_ucode_rom.sv
// ---------------------------------------------------------------------------
// qbr_ucode_rom
// Read-only program of the sequencer: one control word per step.
// ---------------------------------------------------------------------------
module qbr_ucode_rom (
    input  logic [qbr_pkg::PC_W-1:0] i_pc,
    output qbr_pkg::t_ctrl           o_ctrl
);

    function automatic qbr_pkg::t_ctrl mk(
        input qbr_pkg::t_cond           c,
        input logic [qbr_pkg::PC_W-1:0] tgt,
        input qbr_pkg::t_mul            m,
        input qbr_pkg::t_add            a,
        input qbr_pkg::t_xsel           x,
        input qbr_pkg::t_act            act,
        input logic [1:0]               st
    );
        qbr_pkg::t_ctrl w;
        w.cond   = c;
        w.target = tgt;
        w.mul    = m;
        w.add    = a;
        w.xsel   = x;
        w.act    = act;
        w.status = st;
        return w;
    endfunction

    // Five-step Horner evaluation at offset k of an evaluation block
    function automatic qbr_pkg::t_ctrl ev(input int k);
        qbr_pkg::t_ctrl w;
        w = mk(qbr_pkg::C_NEXT, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE, qbr_pkg::ADD_NONE,
               qbr_pkg::X_HOLD, qbr_pkg::ACT_NONE, qbr_pkg::ST_WIDTH);
        case (k)
            0: begin
                w.mul = qbr_pkg::MUL_C2X;
            end
            1: begin
                w.add = qbr_pkg::ADD_T_FORM;
            end
            2: begin
                w.mul = qbr_pkg::MUL_LOX;
            end
            3: begin
                w.mul = qbr_pkg::MUL_HIX;
                w.add = qbr_pkg::ADD_A_INIT;
            end
            default: begin
                w.add = qbr_pkg::ADD_A_HI;
            end
        endcase
        return w;
    endfunction

    always_comb begin
        case (i_pc)
            qbr_pkg::PC_IDLE: begin
                o_ctrl = mk(qbr_pkg::C_NO_INPUT, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_IN, qbr_pkg::ACT_LOAD,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_EVA:        o_ctrl = ev(0);
            qbr_pkg::PC_EVA + 5'd1: o_ctrl = ev(1);
            qbr_pkg::PC_EVA + 5'd2: o_ctrl = ev(2);
            qbr_pkg::PC_EVA + 5'd3: o_ctrl = ev(3);
            qbr_pkg::PC_EVA + 5'd4: o_ctrl = ev(4);
            qbr_pkg::PC_A_CHK: begin
                o_ctrl = mk(qbr_pkg::C_ZERO, qbr_pkg::PC_FIN_A, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_B, qbr_pkg::ACT_SAVE_SA,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_EVB:        o_ctrl = ev(0);
            qbr_pkg::PC_EVB + 5'd1: o_ctrl = ev(1);
            qbr_pkg::PC_EVB + 5'd2: o_ctrl = ev(2);
            qbr_pkg::PC_EVB + 5'd3: o_ctrl = ev(3);
            qbr_pkg::PC_EVB + 5'd4: o_ctrl = ev(4);
            qbr_pkg::PC_B_CHK: begin
                o_ctrl = mk(qbr_pkg::C_ZERO, qbr_pkg::PC_FIN_B, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_NONE,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_SIGN: begin
                o_ctrl = mk(qbr_pkg::C_SAME, qbr_pkg::PC_FIN_NONE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_NONE,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_LOOP: begin
                o_ctrl = mk(qbr_pkg::C_NARROW, qbr_pkg::PC_FIN_MID, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_MID, qbr_pkg::ACT_NONE,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_EVM:        o_ctrl = ev(0);
            qbr_pkg::PC_EVM + 5'd1: o_ctrl = ev(1);
            qbr_pkg::PC_EVM + 5'd2: o_ctrl = ev(2);
            qbr_pkg::PC_EVM + 5'd3: o_ctrl = ev(3);
            qbr_pkg::PC_EVM + 5'd4: o_ctrl = ev(4);
            qbr_pkg::PC_M_CHK: begin
                o_ctrl = mk(qbr_pkg::C_ZERO, qbr_pkg::PC_FIN_X, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_UPDATE,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_TAIL: begin
                o_ctrl = mk(qbr_pkg::C_WIDE, qbr_pkg::PC_EVM, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_MID, qbr_pkg::ACT_NONE,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_FIN_MID: begin
                o_ctrl = mk(qbr_pkg::C_ALWAYS, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_EMIT_MID,
                            qbr_pkg::ST_WIDTH);
            end
            qbr_pkg::PC_FIN_A: begin
                o_ctrl = mk(qbr_pkg::C_ALWAYS, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_EMIT_A,
                            qbr_pkg::ST_EXACT);
            end
            qbr_pkg::PC_FIN_B: begin
                o_ctrl = mk(qbr_pkg::C_ALWAYS, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_EMIT_B,
                            qbr_pkg::ST_EXACT);
            end
            qbr_pkg::PC_FIN_NONE: begin
                o_ctrl = mk(qbr_pkg::C_ALWAYS, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_EMIT_NONE,
                            qbr_pkg::ST_NOSIGN);
            end
            qbr_pkg::PC_FIN_X: begin
                o_ctrl = mk(qbr_pkg::C_ALWAYS, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_EMIT_X,
                            qbr_pkg::ST_EXACT);
            end
            default: begin
                o_ctrl = mk(qbr_pkg::C_ALWAYS, qbr_pkg::PC_IDLE, qbr_pkg::MUL_NONE,
                            qbr_pkg::ADD_NONE, qbr_pkg::X_HOLD, qbr_pkg::ACT_NONE,
                            qbr_pkg::ST_WIDTH);
            end
        endcase
    end

endmodule

FILE: rtl/qbr_datapath.sv
// ---------------------------------------------------------------------------
// qbr_datapath
// Interval registers, shared multiplier and wide accumulator for the exact
// sign evaluation of the quadratic.
// ---------------------------------------------------------------------------
module qbr_datapath (
    input  logic                               i_clk,
    input  qbr_pkg::t_ctrl                     i_ctrl,
    input  qbr_pkg::t_cfg                      i_cfg,
    input  logic signed [qbr_pkg::VALUE_W-1:0] i_left,
    input  logic signed [qbr_pkg::VALUE_W-1:0] i_right,
    output qbr_pkg::t_flags                    o_flags,
    output logic signed [qbr_pkg::VALUE_W-1:0] o_root
);

    localparam int W = qbr_pkg::VALUE_W;

    logic signed [W-1:0]               r_a, n_a;
    logic signed [W-1:0]               r_b, n_b;
    logic signed [W-1:0]               r_x, n_x;
    logic                              r_sa, n_sa;
    logic signed [qbr_pkg::P_W-1:0]    r_p, n_p;
    logic signed [qbr_pkg::T_W-1:0]    r_t, n_t;
    logic signed [qbr_pkg::ACC_W-1:0]  r_acc, n_acc;

    logic signed [W:0]                 w_sum;
    logic signed [W:0]                 w_diff;
    logic signed [W-1:0]               w_mid;
    logic [qbr_pkg::TOL_W-1:0]         w_tol;
    logic signed [qbr_pkg::MA_W-1:0]   w_op;
    logic signed [qbr_pkg::P_W-1:0]    w_prod;
    logic                              w_neg;

    assign w_sum  = (W+1)'(r_a) + (W+1)'(r_b);
    assign w_mid  = w_sum[W:1];
    assign w_diff = (W+1)'(r_b) - (W+1)'(r_a);
    assign w_tol  = (i_cfg.tol < qbr_pkg::TOL_MIN) ? qbr_pkg::TOL_MIN : i_cfg.tol;
    assign w_neg  = r_acc[qbr_pkg::ACC_W-1];

    // Multiplier operand: c2, low word of t (unsigned), or high word of t
    always_comb begin
        case (i_ctrl.mul)
            qbr_pkg::MUL_C2X: w_op = qbr_pkg::MA_W'($signed(i_cfg.c2));
            qbr_pkg::MUL_LOX: w_op = $signed(qbr_pkg::MA_W'(r_t[W-1:0]));
            qbr_pkg::MUL_HIX: w_op = r_t[qbr_pkg::T_W-1:W];
            default:          w_op = '0;
        endcase
    end

    assign w_prod = qbr_pkg::P_W'(w_op) * qbr_pkg::P_W'(r_x);

    always_comb begin
        n_a   = r_a;
        n_b   = r_b;
        n_x   = r_x;
        n_sa  = r_sa;
        n_p   = r_p;
        n_t   = r_t;
        n_acc = r_acc;

        if (i_ctrl.mul != qbr_pkg::MUL_NONE) begin
            n_p = w_prod;
        end

        case (i_ctrl.add)
            qbr_pkg::ADD_T_FORM: begin
                n_t = qbr_pkg::T_W'(r_p)
                    + (qbr_pkg::T_W'($signed(i_cfg.c1)) <<< qbr_pkg::FRAC_W);
            end
            qbr_pkg::ADD_A_INIT: begin
                n_acc = qbr_pkg::ACC_W'(r_p)
                      + (qbr_pkg::ACC_W'($signed(i_cfg.c0)) <<< (2 * qbr_pkg::FRAC_W));
            end
            qbr_pkg::ADD_A_HI: begin
                n_acc = r_acc + (qbr_pkg::ACC_W'(r_p) <<< W);
            end
            default: begin
            end
        endcase

        case (i_ctrl.xsel)
            qbr_pkg::X_IN:  n_x = i_left;
            qbr_pkg::X_B:   n_x = r_b;
            qbr_pkg::X_MID: n_x = w_mid;
            default:        n_x = r_x;
        endcase

        case (i_ctrl.act)
            qbr_pkg::ACT_LOAD: begin
                n_a = i_left;
                n_b = i_right;
            end
            qbr_pkg::ACT_SAVE_SA: begin
                n_sa = w_neg;
            end
            qbr_pkg::ACT_UPDATE: begin
                // keep the half whose ends differ in sign
                if (w_neg != r_sa) begin
                    n_b = r_x;
                end else begin
                    n_a = r_x;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_x   <= n_x;
        r_sa  <= n_sa;
        r_p   <= n_p;
        r_t   <= n_t;
        r_acc <= n_acc;
    end

    assign o_flags.zero   = (r_acc == '0);
    assign o_flags.same   = (w_neg == r_sa);
    assign o_flags.narrow = (w_diff < $signed({2'b00, w_tol}));

    always_comb begin
        case (i_ctrl.act)
            qbr_pkg::ACT_EMIT_A:   o_root = r_a;
            qbr_pkg::ACT_EMIT_B:   o_root = r_b;
            qbr_pkg::ACT_EMIT_MID: o_root = w_mid;
            qbr_pkg::ACT_EMIT_X:   o_root = r_x;
            default:               o_root = '0;
        endcase
    end

endmodule

FILE: rtl/quadratic_bisection_root.sv
// ---------------------------------------------------------------------------
// quadratic_bisection_root
// Bisection root finder for c2*x^2 + c1*x + c0 in signed Q16.16.
// Input stream (s_axis): one transfer carries an interval, left_end in
// tdata[31:0] and right_end in tdata[63:32]. Output stream (m_axis): one
// transfer per interval, root in tdata[31:0] and status in tdata[33:32]
// (0 converged by width, 1 exact zero, 2 no sign change with root 0).
// Configuration: a cfg write transfer sets register i_cfg_index (0 coef_square,
// 1 coef_linear, 2 coef_const, 3 tolerance); write only while no interval is
// in flight. o_cfg_ready is always high.
// Operation: a five-step Horner evaluation per point on the one shared 33x32
// multiplier plus two steps of test and update per halving, with up to about
// 32 halvings, fewer on an exact root at an end or a midpoint. One item is in
// work at a time; o_s_tready is high only at the idle step, so a new interval
// is taken only once the previous one has left its final step. Reset restores
// coefficients (1, -5, 3), tolerance 2 ulp, empties the result register and
// parks the sequencer at idle. A stalled receiver holds the result; the next
// interval may be taken meanwhile and its result waits at the final step
// until the slot frees.
// ---------------------------------------------------------------------------
module quadratic_bisection_root (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qbr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [qbr_pkg::VALUE_W-1:0]         i_cfg_data,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [qbr_pkg::IN_TW-1:0]           i_s_tdata,  // left_end, right_end
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [qbr_pkg::OUT_TW-1:0]          o_m_tdata   // root, status, zero pad
);

    localparam int W = qbr_pkg::VALUE_W;

    qbr_pkg::t_cfg               r_cfg;
    logic [qbr_pkg::PC_W-1:0]    r_pc, n_pc;
    logic                        r_out_valid;
    logic signed [W-1:0]         r_out_root;
    logic [1:0]                  r_out_status;

    qbr_pkg::t_ctrl              w_ctrl;
    qbr_pkg::t_flags             w_flags;
    logic signed [W-1:0]         w_root;
    logic                        w_take;
    logic                        w_emit;
    logic                        w_stall;

    // Control store lookup for the current step
    qbr_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_ctrl (w_ctrl)
    );

    qbr_datapath u_dp (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_cfg   (r_cfg),
        .i_left  ($signed(i_s_tdata[W-1:0])),
        .i_right ($signed(i_s_tdata[2*W-1:W])),
        .o_flags (w_flags),
        .o_root  (w_root)
    );

    // Jump condition of the current control word
    always_comb begin
        case (w_ctrl.cond)
            qbr_pkg::C_NEXT:     w_take = 1'b0;
            qbr_pkg::C_ALWAYS:   w_take = 1'b1;
            qbr_pkg::C_NO_INPUT: w_take = !i_s_tvalid;
            qbr_pkg::C_ZERO:     w_take = w_flags.zero;
            qbr_pkg::C_SAME:     w_take = w_flags.same;
            qbr_pkg::C_NARROW:   w_take = w_flags.narrow;
            qbr_pkg::C_WIDE:     w_take = !w_flags.narrow;
            default:             w_take = 1'b1;
        endcase
    end

    assign w_emit = (w_ctrl.act == qbr_pkg::ACT_EMIT_A)
                 || (w_ctrl.act == qbr_pkg::ACT_EMIT_B)
                 || (w_ctrl.act == qbr_pkg::ACT_EMIT_NONE)
                 || (w_ctrl.act == qbr_pkg::ACT_EMIT_MID)
                 || (w_ctrl.act == qbr_pkg::ACT_EMIT_X);

    // Hold the final step while the result slot is still occupied
    assign w_stall = w_emit && r_out_valid && !i_m_tready;

    always_comb begin
        if (w_stall) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_ctrl.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= qbr_pkg::PC_IDLE;
            r_out_valid <= 1'b0;
            r_cfg.c2    <= qbr_pkg::C2_RESET;
            r_cfg.c1    <= qbr_pkg::C1_RESET;
            r_cfg.c0    <= qbr_pkg::C0_RESET;
            r_cfg.tol   <= qbr_pkg::TOL_MIN;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    qbr_pkg::REG_SQUARE: r_cfg.c2  <= i_cfg_data;
                    qbr_pkg::REG_LINEAR: r_cfg.c1  <= i_cfg_data;
                    qbr_pkg::REG_CONST:  r_cfg.c0  <= i_cfg_data;
                    qbr_pkg::REG_TOL:    r_cfg.tol <= i_cfg_data[qbr_pkg::TOL_W-1:0];
                    default: begin
                    end
                endcase
            end

            // load the result slot, or drop it once transferred
            if (w_emit && !w_stall) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && !w_stall) begin
            r_out_root   <= w_root;
            r_out_status <= w_ctrl.status;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_pc == qbr_pkg::PC_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = qbr_pkg::OUT_TW'({r_out_status, r_out_root});

endmodule

FILE: rtl/qbr_checker.sv
// ---------------------------------------------------------------------------
// qbr_checker
// Port-level checks of the bisection root finder, bound to the top level.
// ---------------------------------------------------------------------------
`include "quadratic_bisection_root_assert.svh"

module qbr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [qbr_pkg::OUT_TW-1:0]    o_m_tdata
);

    localparam int W = qbr_pkg::VALUE_W;

    logic w_nosign;

    assign w_nosign = o_m_tvalid && (o_m_tdata[W+1:W] == qbr_pkg::ST_NOSIGN);

    // a pending result stays offered until transferred
    `QBR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // one interval at a time: busy right after an input transfer
    `QBR_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // no sign change reports a zero root
    `QBR_ASSERT_NOW(a_nosign_root, i_clk, i_rst_n, w_nosign, o_m_tdata[W-1:0] == '0)

    // no status code beyond the no-sign-change code is produced
    `QBR_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[W+1:W] <= qbr_pkg::ST_NOSIGN)

endmodule

bind quadratic_bisection_root qbr_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/quadratic_bisection_root_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadratic_bisection_root_tb
// Self-checking bench for the bisection root finder. Intervals go in on the
// slave stream and coefficient/tolerance writes go in on the cfg channel. An
// exact wide-integer evaluation of the polynomial predicts root and status
// for each interval. Results are compared in order as they leave the master
// stream. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module quadratic_bisection_root_tb;
    import qbr_pkg::*;

    localparam int     HALF_PERIOD   = 4;
    localparam int     RESET_CYCLES  = 7;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_ITEMS   = 100;
    // idle margin after the last result at the end of the run
    localparam int     SETTLE_CYCLES = 300;
    localparam longint CYCLE_LIMIT   = 2000000;

    localparam logic signed [VALUE_W-1:0] ONE     = VALUE_W'(1 <<< FRAC_W);
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] root;
        logic [1:0]                status;
    } t_root_answer;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [VALUE_W-1:0]      i_cfg_data;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_TW-1:0]        i_s_tdata;   // left_end, right_end
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [OUT_TW-1:0]       o_m_tdata;   // root, status, zero pad

    // bench copy of the coefficient and tolerance registers
    logic signed [VALUE_W-1:0] cfg_square;
    logic signed [VALUE_W-1:0] cfg_linear;
    logic signed [VALUE_W-1:0] cfg_const;
    logic [TOL_W-1:0]          cfg_tol;

    t_root_answer pending_answers[$];
    int           error_count   = 0;
    int           results_seen  = 0;
    int           seen_by_ready = 0;
    int           ready_hold    = 0;
    bit           gaps_on       = 1'b1;
    longint       cycle_count   = 0;

    // roots the current random polynomial was built from
    logic signed [VALUE_W-1:0] root_lo = '0;
    logic signed [VALUE_W-1:0] root_hi = '0;

    quadratic_bisection_root i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    function automatic logic signed [VALUE_W-1:0] to_fixed(int whole);
        return VALUE_W'(whole <<< FRAC_W);
    endfunction

    function automatic int draw_gap();
        return gaps_on ? int'($urandom_range(0, 3)) : 0;
    endfunction

    // Sign of c2*x^2 + c1*x*2^F + c0*2^2F; 128 bits hold it exactly, so
    // only the sign and zero test matter.
    function automatic int poly_sign_at(logic signed [VALUE_W-1:0] x);
        logic signed [127:0] xw, sq, lin, cst, acc;
        xw  = x;
        sq  = cfg_square;
        lin = cfg_linear;
        cst = cfg_const;
        acc = (sq * xw + (lin <<< FRAC_W)) * xw + (cst <<< (2 * FRAC_W));
        if (acc < 0)
            return -1;
        return (acc == 0) ? 0 : 1;
    endfunction

    function automatic t_root_answer predict_root(logic signed [VALUE_W-1:0] left_end,
                                                  logic signed [VALUE_W-1:0] right_end);
        t_root_answer ans;
        longint       lo, hi, mid, stop;
        int           s_lo, s_hi, s_mid;
        lo   = left_end;
        hi   = right_end;
        // a tolerance under two ulp would never end the loop; clamp it
        stop = (cfg_tol < TOL_MIN) ? longint'(TOL_MIN) : longint'(cfg_tol);
        s_lo = poly_sign_at(left_end);
        s_hi = poly_sign_at(right_end);
        ans.root   = '0;
        ans.status = ST_WIDTH;
        if (s_lo == 0) begin
            ans.root   = left_end;
            ans.status = ST_EXACT;
        end else if (s_hi == 0) begin
            ans.root   = right_end;
            ans.status = ST_EXACT;
        end else if (s_lo == s_hi) begin
            ans.status = ST_NOSIGN;
        end else begin
            // a reversed interval has negative width and skips the loop
            while (hi - lo >= stop) begin
                mid   = (lo + hi) >>> 1;
                s_mid = poly_sign_at(VALUE_W'(mid));
                if (s_mid == 0) begin
                    ans.root   = VALUE_W'(mid);
                    ans.status = ST_EXACT;
                    return ans;
                end
                if (s_mid != s_lo)
                    hi = mid;
                else
                    lo = mid;
            end
            ans.root = VALUE_W'((lo + hi) >>> 1);
        end
        return ans;
    endfunction

    // -----------------------------------------------------------------------
    // Result checking and receiver stalls
    // -----------------------------------------------------------------------

    always @(posedge i_clk) begin : check_results
        t_root_answer want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_answers.size() == 0) begin
                $error("unexpected result: root %0d status %0d",
                       $signed(o_m_tdata[VALUE_W-1:0]), o_m_tdata[VALUE_W+1:VALUE_W]);
                error_count++;
            end else begin
                want = pending_answers.pop_front();
                if (o_m_tdata[VALUE_W-1:0] !== want.root) begin
                    $error("root: expected %0d, actual %0d",
                           want.root, $signed(o_m_tdata[VALUE_W-1:0]));
                    error_count++;
                end
                if (o_m_tdata[VALUE_W+1:VALUE_W] !== want.status) begin
                    $error("status: expected %0d, actual %0d",
                           want.status, o_m_tdata[VALUE_W+1:VALUE_W]);
                    error_count++;
                end
            end
        end
    end

    // After each result transfer, drop tready for a random number of cycles.
    always @(negedge i_clk) begin
        if (results_seen != seen_by_ready) begin
            seen_by_ready = results_seen;
            ready_hold    = draw_gap();
        end
        if (ready_hold > 0) begin
            i_m_tready <= 1'b0;
            ready_hold--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Drivers; every task starts and ends just after a falling edge
    // -----------------------------------------------------------------------

    task automatic send_interval(input logic signed [VALUE_W-1:0] left_end,
                                 input logic signed [VALUE_W-1:0] right_end);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TW'({right_end, left_end});
        do @(posedge i_clk); while (!o_s_tready);
        pending_answers.push_back(predict_root(left_end, right_end));
        @(negedge i_clk);
    endtask

    // Drop the input stream and hold until every result has come back.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [VALUE_W-1:0]   data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            REG_SQUARE: cfg_square = data;
            REG_LINEAR: cfg_linear = data;
            REG_CONST:  cfg_const  = data;
            REG_TOL:    cfg_tol    = data[TOL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Drain first: registers change only while no interval is in flight.
    task automatic set_coefficients(input logic signed [VALUE_W-1:0] c2,
                                    input logic signed [VALUE_W-1:0] c1,
                                    input logic signed [VALUE_W-1:0] c0,
                                    input logic [VALUE_W-1:0]        tol_word);
        wait_idle();
        write_register(REG_SQUARE, c2);
        write_register(REG_LINEAR, c1);
        write_register(REG_CONST, c0);
        write_register(REG_TOL, tol_word);
        i_cfg_valid <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset polynomial x^2 - 5x + 3, tolerance 2 ulp.
    task automatic test_default_coefficients();
        send_interval('0, ONE);
        send_interval(ONE, to_fixed(10));
        send_interval(VAL_MIN, VAL_MAX);      // both ends far positive
        send_interval('0, '0);
        send_interval(ONE, '0);               // reversed, ends differ in sign
    endtask

    // (x - 1)(x - 2): roots on an end point or the first midpoint, and a one-point interval.
    task automatic test_exact_roots();
        set_coefficients(ONE, -to_fixed(3), to_fixed(2), TOL_MIN);
        send_interval(ONE, to_fixed(5));
        send_interval('0, to_fixed(2));
        send_interval(ONE / 4, ONE * 7 / 4);  // midpoint is exactly 1.0
        send_interval(ONE * 3 / 2, ONE * 3 / 2);
    endtask

    task automatic test_register_extremes();
        // tolerance under two ulp clamps to two
        set_coefficients(C2_RESET, C1_RESET, C0_RESET, 0);
        send_interval('0, ONE);
        set_coefficients(C2_RESET, C1_RESET, C0_RESET, 1);
        send_interval(ONE, to_fixed(10));
        // f(x) = x with the widest tolerance; data bit 31 falls outside it
        set_coefficients('0, ONE, '0, '1);
        send_interval(VAL_MIN, VAL_MAX);
        send_interval(-ONE, ONE);
        set_coefficients(VAL_MIN, VAL_MAX, VAL_MIN, TOL_MIN);
        send_interval(VAL_MIN, VAL_MAX);
        send_interval(-1, 1);
        send_interval('0, VAL_MAX);
        set_coefficients(VAL_MAX, VAL_MIN, VAL_MAX, 3);
        send_interval('0, VAL_MAX);
        send_interval(VAL_MIN, '0);
        // zero polynomial: every left end is a root
        set_coefficients('0, '0, '0, TOL_MIN);
        send_interval(5, 7);
    endtask

    function automatic logic signed [VALUE_W-1:0] random_root();
        if ($urandom_range(0, 1) != 0)
            return to_fixed(int'($urandom_range(0, 300)) - 150);
        return VALUE_W'(int'($urandom_range(0, 300 * 65536)) - 150 * 65536);
    endfunction

    // Mostly s*(x - r1)(x - r2) so intervals can bracket a known root;
    // sometimes raw random coefficients.
    task automatic pick_random_polynomial();
        logic signed [VALUE_W-1:0] c2, c1, c0, sgn;
        logic [VALUE_W-1:0]        tol_word;
        longint                    prod;
        root_lo = random_root();
        root_hi = random_root();
        if ($urandom_range(0, 4) != 0) begin
            sgn  = ($urandom_range(0, 1) != 0) ? ONE : -ONE;
            prod = (longint'(root_lo) * longint'(root_hi)) >>> FRAC_W;
            c2   = sgn;
            c1   = (sgn == ONE) ? -(root_lo + root_hi) : (root_lo + root_hi);
            c0   = (sgn == ONE) ? VALUE_W'(prod) : VALUE_W'(-prod);
        end else begin
            c2 = $urandom();
            c1 = $urandom();
            c0 = $urandom();
        end
        case ($urandom_range(0, 5))
            0:       tol_word = $urandom_range(0, 1);
            1:       tol_word = $urandom();
            2:       tol_word = $urandom_range(2, 1 << FRAC_W);
            default: tol_word = $urandom_range(2, 16);
        endcase
        set_coefficients(c2, c1, c0, tol_word);
    endtask

    task automatic send_random_interval();
        logic signed [VALUE_W-1:0] center, a, b, d;
        int                        reach;
        center = ($urandom_range(0, 1) != 0) ? root_lo : root_hi;
        reach  = 1 << $urandom_range(0, 24);
        case ($urandom_range(0, 9))
            0, 1: begin
                // noise over the whole range, either order
                a = $urandom();
                b = $urandom();
            end
            2: begin
                // symmetric around the root: midpoint hits it exactly
                d = $urandom_range(0, reach);
                a = center - d;
                b = center + d;
            end
            3: begin
                a = center + $urandom_range(0, reach);
                b = center - $urandom_range(0, reach);
            end
            default: begin
                a = center - $urandom_range(0, reach);
                b = center + $urandom_range(0, reach);
            end
        endcase
        send_interval(a, b);
    endtask

    task automatic test_random_intervals();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // about one phase in four runs both sides without gaps
            gaps_on = ($urandom_range(0, 3) != 0);
            pick_random_polynomial();
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_interval();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SQUARE;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        cfg_square  = C2_RESET;
        cfg_linear  = C1_RESET;
        cfg_const   = C0_RESET;
        cfg_tol     = TOL_MIN;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_coefficients();
        test_exact_roots();
        test_register_extremes();
        test_random_intervals();

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/qbr_pkg.sv
rtl/qbr_ucode_rom.sv
rtl/qbr_datapath.sv
rtl/quadratic_bisection_root.sv
rtl/qbr_checker.sv
tb/quadratic_bisection_root_tb.sv
